>>> hdl/tfcd_pkg.sv
// shared types, constants and helpers of the tdc code density calibration unit
package tfcd_pkg;

   localparam int NUM_PLANES   = 1;
   localparam int NUM_SECTIONS = 3;
   localparam int NUM_ANODES   = 6;
   localparam int NUM_BINS     = 1000;

   localparam int CHANNELS  = NUM_PLANES * NUM_SECTIONS * NUM_ANODES;
   localparam int SEC_AN    = NUM_SECTIONS * NUM_ANODES;
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int BIN_W     = $clog2(NUM_BINS);
   localparam int BIN_AW    = CH_W + BIN_W;
   localparam int BIN_DEPTH = CHANNELS << BIN_W;

   localparam int CNT_W          = 32;
   localparam int VAL_W          = 15;
   localparam int DIV_N_W        = CNT_W + VAL_W;
   localparam int FULL_SCALE_Q12 = 20480;

   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_BAD_CHANNEL = 2'd1;
   localparam logic [1:0] STAT_NO_CAL      = 2'd2;
   localparam logic [1:0] STAT_BAD_BIN     = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [3:0]  plane;
      logic [3:0]  section;
      logic [3:0]  anode;
      logic [11:0] fine_time;
      logic [11:0] query_bin;
   } req_item_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] calibrated_ns_q12;
   } rsp_item_type;

   typedef struct packed {
      logic [CNT_W-1:0] entries;
      logic [CNT_W-1:0] in_range;
   } chan_word_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
   endfunction

endpackage

>>> hdl/tfcd_ram.sv
// generic simple dual-port ram with registered read data
module tfcd_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 32
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hdl/tfcd_divider.sv
// restoring divider, one quotient bit per cycle, quotient known to fit
module tfcd_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tfcd_pkg::DIV_N_W-1:0]  dividend,
   input  logic [tfcd_pkg::CNT_W-1:0]    divisor,
   output logic                          done,
   output logic [tfcd_pkg::VAL_W-1:0]    quotient
);
   import tfcd_pkg::*;

   localparam int STEP_W = $clog2(VAL_W + 1);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [VAL_W-1:0]  low_ff, low_in;
   logic [VAL_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [CNT_W:0] shifted;
   logic [CNT_W:0] diff;
   logic           ge;

   always_comb begin
      shifted = {rem_ff, low_ff[VAL_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = (shifted >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[DIV_N_W-1:VAL_W];
         low_in  = dividend[VAL_W-1:0];
         dvs_in  = divisor;
         step_in = STEP_W'(VAL_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
         low_in  = {low_ff[VAL_W-2:0], 1'b0};
         quo_in  = {quo_ff[VAL_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hdl/tdc_fine_time_code_density_calibration_unit.sv
// top level: per-channel fine-time histograms and code density calibration
//
// Takes one item at a time. After reset the histogram and channel memories are cleared
// one row per cycle, during which no item is taken. A record item steps through lookup
// read, read-modify-write, reply and back to idle. A query item reads the channel
// counters, then sums the histogram one bin per cycle from the bin memory port and
// divides with a 15-step serial divider. Items with a bad channel, and queries with a
// bad bin, reply with an error status after the lookup. The result register lets a new
// item start while the previous result waits to be taken.
module tdc_fine_time_code_density_calibration_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tfcd_pkg::req_item_type       req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tfcd_pkg::rsp_item_type       rsp_item,
   input  logic                         csr_we,
   input  logic [tfcd_pkg::CNT_W-1:0]   csr_wdata
);
   import tfcd_pkg::*;

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LOOKUP = 4'd2;
   localparam logic [3:0] S_RECORD = 4'd3;
   localparam logic [3:0] S_CHECK  = 4'd4;
   localparam logic [3:0] S_SUM    = 4'd5;
   localparam logic [3:0] S_DIVIDE = 4'd6;
   localparam logic [3:0] S_WAIT   = 4'd7;
   localparam logic [3:0] S_REPLY  = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [BIN_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0] min_stat_ff, min_stat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff, rsp_item_in;

   logic             op_ff, op_in;
   logic [CH_W-1:0]  ch_ff, ch_in;
   logic             chan_ok_ff, chan_ok_in;
   logic [BIN_W-1:0] bin_ff, bin_in;
   logic             bin_ok_ff, bin_ok_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] acc_ff, acc_in;
   logic [BIN_W-1:0] idx_ff, idx_in;
   logic [BIN_W-1:0] data_bin_ff, data_bin_in;
   logic [1:0]       status_ff, status_in;
   logic [VAL_W-1:0] value_ff, value_in;

   logic              bin_we;
   logic [BIN_AW-1:0] bin_waddr, bin_raddr;
   logic [CNT_W-1:0]  bin_wdata, bin_rdata;
   logic              chan_we;
   logic [CH_W-1:0]   chan_waddr, chan_raddr;
   chan_word_type     chan_wdata, chan_rdata;

   logic                div_start, div_done;
   logic [DIV_N_W-1:0]  div_dividend;
   logic [VAL_W-1:0]    div_quotient;

   logic             plane_ok, section_ok, anode_ok;
   logic [11:0]      ch_wide;
   logic [11:0]      sel_bin;
   logic [CNT_W:0]   acc_sum;

   tfcd_ram #(
      .DEPTH  (BIN_DEPTH),
      .ADDR_W (BIN_AW),
      .WIDTH  (CNT_W)
   ) u_bin_ram (
      .clock (clock),
      .we    (bin_we),
      .waddr (bin_waddr),
      .wdata (bin_wdata),
      .raddr (bin_raddr),
      .rdata (bin_rdata)
   );

   tfcd_ram #(
      .DEPTH  (CHANNELS),
      .ADDR_W (CH_W),
      .WIDTH  ($bits(chan_word_type))
   ) u_chan_ram (
      .clock (clock),
      .we    (chan_we),
      .waddr (chan_waddr),
      .wdata (chan_wdata),
      .raddr (chan_raddr),
      .rdata (chan_rdata)
   );

   tfcd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // 5 ns in q12 is 2^14 + 2^12
   assign div_dividend = DIV_N_W'({acc_ff, 14'b0}) + DIV_N_W'({acc_ff, 12'b0});

   assign plane_ok   = (req_item.plane != 4'd0) && ({1'b0, req_item.plane} <= 5'(NUM_PLANES));
   assign section_ok = (req_item.section != 4'd0)
                       && ({1'b0, req_item.section} <= 5'(NUM_SECTIONS));
   assign anode_ok   = (req_item.anode != 4'd0) && ({1'b0, req_item.anode} <= 5'(NUM_ANODES));
   assign ch_wide    = 12'(12'(req_item.plane - 4'd1) * 12'(SEC_AN))
                       + 12'(12'(req_item.section - 4'd1) * 12'(NUM_ANODES))
                       + 12'(req_item.anode - 4'd1);
   assign sel_bin    = (req_item.operation == OP_QUERY) ? req_item.query_bin
                                                        : req_item.fine_time;

   // cumulative count before it is clamped to the in-range total
   assign acc_sum = {1'b0, acc_ff} + {1'b0, bin_rdata};

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      min_stat_in  = csr_we ? csr_wdata : min_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      chan_ok_in   = chan_ok_ff;
      bin_in       = bin_ff;
      bin_ok_in    = bin_ok_ff;
      total_in     = total_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      data_bin_in  = data_bin_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      bin_we       = 1'b0;
      bin_waddr    = {ch_ff, bin_ff};
      bin_wdata    = sat_inc(bin_rdata);
      bin_raddr    = {ch_ff, bin_ff};
      chan_we      = 1'b0;
      chan_waddr   = ch_ff;
      chan_wdata.entries  = sat_inc(chan_rdata.entries);
      chan_wdata.in_range = bin_ok_ff ? sat_inc(chan_rdata.in_range) : chan_rdata.in_range;
      chan_raddr   = ch_ff;
      div_start    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            bin_we     = 1'b1;
            bin_waddr  = clr_cnt_ff;
            bin_wdata  = '0;
            chan_we    = 1'b1;
            chan_waddr = clr_cnt_ff[BIN_AW-1:BIN_W];
            chan_wdata = '0;
            if (clr_cnt_ff == BIN_AW'(BIN_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + BIN_AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in      = req_item.operation;
               ch_in      = ch_wide[CH_W-1:0];
               chan_ok_in = plane_ok && section_ok && anode_ok;
               bin_in     = sel_bin[BIN_W-1:0];
               bin_ok_in  = ({1'b0, sel_bin} < 13'(NUM_BINS));
               state_in   = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            value_in = '0;
            if (!chan_ok_ff) begin
               status_in = STAT_BAD_CHANNEL;
               state_in  = S_REPLY;
            end else if (op_ff == OP_RECORD) begin
               state_in = S_RECORD;
            end else if (!bin_ok_ff) begin
               status_in = STAT_BAD_BIN;
               state_in  = S_REPLY;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_RECORD: begin
            chan_we   = 1'b1;
            bin_we    = bin_ok_ff;
            status_in = STAT_OK;
            state_in  = S_REPLY;
         end
         S_CHECK: begin
            if ((chan_rdata.entries <= min_stat_ff) || (chan_rdata.in_range == '0)) begin
               status_in = STAT_NO_CAL;
               state_in  = S_REPLY;
            end else begin
               total_in    = chan_rdata.in_range;
               acc_in      = '0;
               bin_raddr   = {ch_ff, BIN_W'(0)};
               data_bin_in = '0;
               idx_in      = BIN_W'(1);
               state_in    = S_SUM;
            end
         end
         S_SUM: begin
            acc_in      = (acc_sum > {1'b0, total_ff}) ? total_ff : acc_sum[CNT_W-1:0];
            bin_raddr   = {ch_ff, idx_ff};
            idx_in      = idx_ff + BIN_W'(1);
            data_bin_in = idx_ff;
            if (data_bin_ff == bin_ff) begin
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            div_start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               value_in  = div_quotient;
               status_in = STAT_OK;
               state_in  = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_item_in.status            = status_ff;
               rsp_item_in.calibrated_ns_q12 = value_ff;
               state_in                      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         min_stat_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         min_stat_ff  <= min_stat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      chan_ok_ff  <= chan_ok_in;
      bin_ff      <= bin_in;
      bin_ok_ff   <= bin_ok_in;
      total_ff    <= total_in;
      acc_ff      <= acc_in;
      idx_ff      <= idx_in;
      data_bin_ff <= data_bin_in;
      status_ff   <= status_in;
      value_ff    <= value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_value_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.status != STAT_OK) |-> rsp_item_ff.calibrated_ns_q12 == '0)
      else $error("nonzero value on a result without ok status");

   a_value_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_item_ff.calibrated_ns_q12 <= VAL_W'(FULL_SCALE_Q12))
      else $error("calibrated value above full scale");

   a_acc_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> acc_ff <= total_ff)
      else $error("cumulative count above in-range total");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_WAIT)
      else $error("divider finished outside the wait state");

   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_LOOKUP)
      else $error("accepted item did not start a lookup");

endmodule
